>>> src/atl_pkg.sv
// Package for the accelerometer tilt angle block: shared widths, constants,
// the CORDIC arctangent table and the structs passed between cells.
// No dependencies.
`default_nettype none

package atl_pkg;

    // Number of stages in the square root chain and in the CORDIC chain.
    localparam int SQRT_STEPS   = 28;
    localparam int CORDIC_STEPS = 29;

    // Width of the root remainder and partial root.
    localparam int SQRT_W   = 57;
    // Width of the CORDIC vector components.
    localparam int CORDIC_W = 48;
    // Width of the CORDIC angle accumulator.
    localparam int ACC_W    = 32;

    // Angle constants, in units of 0.01 degree / 65536.
    localparam logic signed [ACC_W-1:0] ANG_NINETY    = 32'sd589824000;
    localparam logic signed [ACC_W-1:0] ANG_HALF_TURN = 32'sd1179648000;
    localparam logic        [ACC_W-1:0] ANG_ROUND     = 32'd32768;

    // Midpoint angle in hundredths of a degree.
    localparam logic [15:0] ANGLE_MID = 16'd18000;

    // Reset value of the shock threshold.
    localparam logic [31:0] SHOCK_RESET = 32'd3221225472;

    // Register indexes on the configuration port.
    localparam logic REG_SHOCK = 1'b0;

    // Partial square root carried along the root chain.
    typedef struct packed {
        logic [SQRT_W-1:0] rem;
        logic [SQRT_W-1:0] res;
    } sqrt_vec_t;

    // Vector and accumulated angle carried along a CORDIC row.
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ACC_W-1:0]    acc;
    } cordic_vec_t;

    // Per-request data that travels beside the arithmetic chains.
    typedef struct packed {
        logic               valid;
        logic               ok;
        logic               xpos;
        logic               ypos;
        logic signed [31:0] xz;
        logic signed [31:0] yz;
        logic [15:0]        ax;
        logic [15:0]        ay;
    } side_t;

    // Arctangent of 2^-i in angle units.
    function automatic logic [ACC_W-1:0] atan_entry(input int i);
        logic [ACC_W-1:0] v;
        case (i)
            0:       v = 32'd294912000;
            1:       v = 32'd174096719;
            2:       v = 32'd91987925;
            3:       v = 32'd46694507;
            4:       v = 32'd23437865;
            5:       v = 32'd11730358;
            6:       v = 32'd5866610;
            7:       v = 32'd2933484;
            8:       v = 32'd1466764;
            9:       v = 32'd733385;
            10:      v = 32'd366693;
            11:      v = 32'd183346;
            12:      v = 32'd91673;
            13:      v = 32'd45837;
            14:      v = 32'd22918;
            15:      v = 32'd11459;
            16:      v = 32'd5730;
            17:      v = 32'd2865;
            18:      v = 32'd1432;
            19:      v = 32'd716;
            20:      v = 32'd358;
            21:      v = 32'd179;
            22:      v = 32'd90;
            23:      v = 32'd45;
            24:      v = 32'd22;
            25:      v = 32'd11;
            26:      v = 32'd6;
            27:      v = 32'd3;
            28:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/atl_if.sv
// Valid/ready channel interfaces for sample requests and angle results.
// No dependencies.
`default_nettype none

interface atl_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_count;
    logic signed [15:0] y_count;
    logic signed [15:0] z_primary_count;
    logic signed [15:0] z_fallback_count;
    logic               x_present;
    logic               y_present;
    logic               z_primary_present;
    logic               z_fallback_present;

    modport source (
        output valid, x_count, y_count, z_primary_count, z_fallback_count,
               x_present, y_present, z_primary_present, z_fallback_present,
        input  ready
    );
    modport sink (
        input  valid, x_count, y_count, z_primary_count, z_fallback_count,
               x_present, y_present, z_primary_present, z_fallback_present,
        output ready
    );
endinterface

interface atl_result_if;
    logic        valid;
    logic        ready;
    logic        set_ok;
    logic [15:0] angle_xoz;
    logic [15:0] angle_yoz;

    modport source (output valid, set_ok, angle_xoz, angle_yoz, input ready);
    modport sink (input valid, set_ok, angle_xoz, angle_yoz, output ready);
endinterface

`default_nettype wire

>>> src/accel_tilt_angles.sv
// Top level of the accelerometer tilt angle block: input checks, squares,
// root and CORDIC cell chains, output register and the APB register port.
// Depends on atl_pkg, atl_if, atl_sqrt_cell and atl_cordic_cell.
//
// Usage: a sample request on the sample channel carries raw X, Y and two Z
// counts with presence flags. Each request yields exactly one result on the
// result channel: set_ok and the XOZ and YOZ angles in hundredths of a
// degree, or all zero for a rejected set. Requests and results are accepted
// when valid and ready are both high.
// From request to result a sample passes three front stages
// (capture, squares, sum and shock check), 28 square root cells, one
// multiply stage, 29 CORDIC cells and the output register.
// Throughput is one request per cycle; the whole pipeline advances as one,
// so a stalled result (ready low while a result is held) freezes every
// stage and holds sample.ready low until the result is taken.
// The shock threshold is written through the APB port at byte address 0.
// Reset clears all stage valid bits and sets the threshold to 3221225472.
`default_nettype none

module accel_tilt_angles
    import atl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    atl_sample_if.sink       sample,
    atl_result_if.source     result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic en;

    // Register port.
    logic [31:0] shock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shock_reg <= SHOCK_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_SHOCK))
        begin
            shock_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SHOCK) ? shock_reg : 32'd0;

    // Output register.
    logic        out_valid_reg;
    logic        out_ok_reg;
    logic [15:0] out_xoz_reg;
    logic [15:0] out_yoz_reg;

    assign en           = !out_valid_reg || result.ready;
    assign sample.ready = en;

    // Capture stage.
    logic               s0_valid_reg;
    logic signed [15:0] s0_x_reg;
    logic signed [15:0] s0_y_reg;
    logic signed [15:0] s0_zp_reg;
    logic signed [15:0] s0_zf_reg;
    logic [3:0]         s0_pres_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_x_reg    <= sample.x_count;
            s0_y_reg    <= sample.y_count;
            s0_zp_reg   <= sample.z_primary_count;
            s0_zf_reg   <= sample.z_fallback_count;
            s0_pres_reg <= {sample.z_fallback_present, sample.z_primary_present,
                            sample.y_present, sample.x_present};
        end
    end

    // Z selection, validity checks and the products.
    logic signed [15:0] z_sel;
    logic               z_any;
    side_t              s1_side_next;
    logic signed [31:0] xx_s;
    logic signed [31:0] yy_s;
    logic signed [31:0] zz_s;

    always_comb
    begin
        z_sel = s0_pres_reg[2] ? s0_zp_reg : s0_zf_reg;
        z_any = s0_pres_reg[2] || s0_pres_reg[3];
        xx_s  = s0_x_reg * s0_x_reg;
        yy_s  = s0_y_reg * s0_y_reg;
        zz_s  = z_sel * z_sel;
        s1_side_next.valid = s0_valid_reg;
        s1_side_next.ok    = s0_pres_reg[0] && s0_pres_reg[1] && z_any &&
                             (z_sel > 0) && (s0_x_reg != 0) && (s0_y_reg != 0);
        s1_side_next.xpos  = s0_x_reg > 0;
        s1_side_next.ypos  = s0_y_reg > 0;
        s1_side_next.xz    = s0_x_reg * z_sel;
        s1_side_next.yz    = s0_y_reg * z_sel;
        s1_side_next.ax    = s0_x_reg[15] ? 16'(-s0_x_reg) : 16'(s0_x_reg);
        s1_side_next.ay    = s0_y_reg[15] ? 16'(-s0_y_reg) : 16'(s0_y_reg);
    end

    side_t       s1_side_reg;
    logic [30:0] s1_xx_reg;
    logic [30:0] s1_yy_reg;
    logic [30:0] s1_zz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
        end
        else if (en)
        begin
            s1_side_reg <= s1_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_xx_reg <= xx_s[30:0];
            s1_yy_reg <= yy_s[30:0];
            s1_zz_reg <= zz_s[30:0];
        end
    end

    // Sum of squares and shock check.
    logic [31:0] sum_sq;
    side_t       s2_side_next;

    always_comb
    begin
        sum_sq          = 32'(s1_xx_reg) + 32'(s1_yy_reg) + 32'(s1_zz_reg);
        s2_side_next    = s1_side_reg;
        s2_side_next.ok = s1_side_reg.ok && (sum_sq <= shock_reg);
    end

    side_t     sq_side [0:SQRT_STEPS];
    sqrt_vec_t sq_vec  [0:SQRT_STEPS];
    sqrt_vec_t s2_vec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_side[0] <= '0;
        end
        else if (en)
        begin
            sq_side[0] <= s2_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_vec_reg.rem <= SQRT_W'({sum_sq, 24'd0});
            s2_vec_reg.res <= '0;
        end
    end

    assign sq_vec[0] = s2_vec_reg;

    // Square root chain, one root bit per cell.
    genvar gi;
    generate
        for (gi = 0; gi < SQRT_STEPS; gi++)
        begin : g_sqrt
            atl_sqrt_cell #(.K(SQRT_STEPS - 1 - gi)) u_cell (
                .clk  (clk),
                .en   (en),
                .vin  (sq_vec[gi]),
                .vout (sq_vec[gi+1])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_side[gi+1] <= '0;
                end
                else if (en)
                begin
                    sq_side[gi+1] <= sq_side[gi];
                end
            end
        end
    endgenerate

    // Multiply stage: numerators and scaled denominators of both angles.
    side_t       m_side_reg;
    logic [43:0] m_p1_reg;
    logic [43:0] m_p2_reg;
    logic signed [43:0] m_q1_reg;
    logic signed [43:0] m_q2_reg;
    logic [27:0] root;
    side_t       sq_last;

    assign sq_last = sq_side[SQRT_STEPS];
    assign root    = sq_vec[SQRT_STEPS].res[27:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_side_reg <= '0;
        end
        else if (en)
        begin
            m_side_reg <= sq_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_p1_reg <= 44'(sq_last.ay) * 44'(root);
            m_p2_reg <= 44'(sq_last.ax) * 44'(root);
            m_q1_reg <= 44'(sq_last.xz) <<< 12;
            m_q2_reg <= 44'(sq_last.yz) <<< 12;
        end
    end

    // Pre-rotation by 90 degrees when the denominator is negative.
    cordic_vec_t c1_vec [0:CORDIC_STEPS];
    cordic_vec_t c2_vec [0:CORDIC_STEPS];
    side_t       cd_side [0:CORDIC_STEPS];

    always_comb
    begin
        if (m_q1_reg < 0)
        begin
            c1_vec[0].x   = CORDIC_W'(m_p1_reg);
            c1_vec[0].y   = CORDIC_W'(-m_q1_reg);
            c1_vec[0].acc = ANG_NINETY;
        end
        else
        begin
            c1_vec[0].x   = CORDIC_W'(m_q1_reg);
            c1_vec[0].y   = CORDIC_W'(m_p1_reg);
            c1_vec[0].acc = '0;
        end
        if (m_q2_reg < 0)
        begin
            c2_vec[0].x   = CORDIC_W'(m_p2_reg);
            c2_vec[0].y   = CORDIC_W'(-m_q2_reg);
            c2_vec[0].acc = ANG_NINETY;
        end
        else
        begin
            c2_vec[0].x   = CORDIC_W'(m_q2_reg);
            c2_vec[0].y   = CORDIC_W'(m_p2_reg);
            c2_vec[0].acc = '0;
        end
    end

    assign cd_side[0] = m_side_reg;

    // Two CORDIC rows, one micro-rotation per cell.
    generate
        for (gi = 0; gi < CORDIC_STEPS; gi++)
        begin : g_cordic
            atl_cordic_cell #(.STEP(gi)) u_xoz (
                .clk  (clk),
                .en   (en),
                .vin  (c1_vec[gi]),
                .vout (c1_vec[gi+1])
            );

            atl_cordic_cell #(.STEP(gi)) u_yoz (
                .clk  (clk),
                .en   (en),
                .vin  (c2_vec[gi]),
                .vout (c2_vec[gi+1])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cd_side[gi+1] <= '0;
                end
                else if (en)
                begin
                    cd_side[gi+1] <= cd_side[gi];
                end
            end
        end
    endgenerate

    // Clamp, round and fold into the full circle.
    function automatic logic [14:0] round_angle(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] cl;
        logic        [ACC_W-1:0] sum;
        begin
            if (acc < 0)
                cl = '0;
            else if (acc > ANG_HALF_TURN)
                cl = ANG_HALF_TURN;
            else
                cl = acc;
            sum = ACC_W'(cl) + ANG_ROUND;
            return sum[30:16];
        end
    endfunction

    side_t       cd_last;
    logic [14:0] a_xoz;
    logic [14:0] a_yoz;
    logic [15:0] r_xoz;
    logic [15:0] r_yoz;

    always_comb
    begin
        cd_last = cd_side[CORDIC_STEPS];
        a_xoz   = round_angle(c1_vec[CORDIC_STEPS].acc);
        a_yoz   = round_angle(c2_vec[CORDIC_STEPS].acc);
        r_xoz   = cd_last.ypos ? ANGLE_MID + 16'(a_xoz) : ANGLE_MID - 16'(a_xoz);
        r_yoz   = cd_last.xpos ? ANGLE_MID - 16'(a_yoz) : ANGLE_MID + 16'(a_yoz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= cd_last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ok_reg  <= cd_last.ok;
            out_xoz_reg <= cd_last.ok ? r_xoz : 16'd0;
            out_yoz_reg <= cd_last.ok ? r_yoz : 16'd0;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.set_ok    = out_ok_reg;
    assign result.angle_xoz = out_xoz_reg;
    assign result.angle_yoz = out_yoz_reg;

endmodule

`default_nettype wire

>>> src/atl_sqrt_cell.sv
// One stage of the restoring square root chain: resolves one root bit.
// Depends on atl_pkg.
`default_nettype none

module atl_sqrt_cell
    import atl_pkg::*;
#(
    parameter int K = 0
)(
    input  wire logic      clk,
    input  wire logic      en,
    input  wire sqrt_vec_t vin,
    output sqrt_vec_t      vout
);

    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * K);

    sqrt_vec_t        vec_reg;
    sqrt_vec_t        vec_next;
    logic [SQRT_W-1:0] trial;

    // Trial subtraction of the current root bit.
    always_comb
    begin
        trial = vin.res + BIT;
        if (vin.rem >= trial)
        begin
            vec_next.rem = vin.rem - trial;
            vec_next.res = (vin.res >> 1) + BIT;
        end
        else
        begin
            vec_next.rem = vin.rem;
            vec_next.res = vin.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vout = vec_reg;

endmodule

`default_nettype wire

>>> src/atl_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its own arctangent constant.
// Depends on atl_pkg.
`default_nettype none

module atl_cordic_cell
    import atl_pkg::*;
#(
    parameter int STEP = 0
)(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire cordic_vec_t vin,
    output cordic_vec_t      vout
);

    localparam logic signed [ACC_W-1:0] ATAN = $signed(atan_entry(STEP));

    cordic_vec_t               vec_reg;
    cordic_vec_t               vec_next;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;

    // Rotate toward the x axis; the direction follows the sign of y.
    always_comb
    begin
        dx = vin.y >>> STEP;
        dy = vin.x >>> STEP;
        if (vin.y > 0)
        begin
            vec_next.x   = vin.x + dx;
            vec_next.y   = vin.y - dy;
            vec_next.acc = vin.acc + ATAN;
        end
        else
        begin
            vec_next.x   = vin.x - dx;
            vec_next.y   = vin.y + dy;
            vec_next.acc = vin.acc - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign vout = vec_reg;

endmodule

`default_nettype wire

>>> test/accel_tilt_angles_test.sv
// Testbench for accel_tilt_angles: a stimulus table, then random sample sets
// under several idle patterns, checked against a behavioral angle predictor.
// Depends on atl_pkg, atl_if and the accel_tilt_angles RTL.
`default_nettype none

module accel_tilt_angles_test
    import atl_pkg::*;
();

    localparam int          CYCLE_LIMIT = 600000;
    localparam int          MAX_REPORTS = 10;
    localparam int          DRAIN_WAIT  = 80;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [31:0] THR_TOP     = 32'd3221225472;

    // One sample set as offered on the request channel.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] zp;
        logic signed [15:0] zf;
        logic               xp;
        logic               yp;
        logic               zpp;
        logic               zfp;
    } sample_set_t;

    // One angle result.
    typedef struct packed {
        logic        ok;
        logic [15:0] xoz;
        logic [15:0] yoz;
    } tilt_t;

    // Stimulus table row: threshold in force, the set, and an optional
    // typed-in result.
    typedef struct packed {
        logic [31:0] thr;
        sample_set_t set;
        logic        typed;
        tilt_t       tilt;
    } tilt_row_t;

    localparam int N_ROWS = 20;
    localparam tilt_row_t TILT_ROWS [N_ROWS] = '{
        // Missing samples and degenerate counts give an all-zero result.
        '{THR_TOP, '{16'sd5, 16'sd7, 16'sd9, 16'sd3, 1'b0, 1'b0, 1'b0, 1'b0},
          1'b1, '0},
        '{THR_TOP, '{16'sd5, 16'sd7, 16'sd9, 16'sd3, 1'b0, 1'b1, 1'b1, 1'b0},
          1'b1, '0},
        '{THR_TOP, '{16'sd5, 16'sd7, 16'sd9, 16'sd3, 1'b1, 1'b0, 1'b1, 1'b0},
          1'b1, '0},
        '{THR_TOP, '{16'sd5, 16'sd7, 16'sd9, 16'sd3, 1'b1, 1'b1, 1'b0, 1'b0},
          1'b1, '0},
        '{THR_TOP, '{16'sd5, 16'sd7, 16'sd0, 16'sd3, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b1, '0},
        // A negative primary Z wins over a good fallback.
        '{THR_TOP, '{16'sd5, 16'sd7, 16'h8000, 16'sd3, 1'b1, 1'b1, 1'b1, 1'b1},
          1'b1, '0},
        '{THR_TOP, '{16'sd0, 16'sd7, 16'sd9, 16'sd3, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b1, '0},
        '{THR_TOP, '{16'sd5, 16'sd0, 16'sd9, 16'sd3, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b1, '0},
        // Accepted sets, from unit counts to the count extremes.
        '{THR_TOP, '{16'sd1, 16'sd1, 16'sd1, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b0, '0},
        '{THR_TOP, '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd0,
          1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{THR_TOP, '{16'h8000, 16'h8000, 16'sd32767, 16'sd0,
          1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{THR_TOP, '{16'h8000, 16'sd32767, 16'sd1, 16'sd0,
          1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{THR_TOP, '{16'sd1, 16'h8000, 16'sd32767, 16'sd0,
          1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{THR_TOP, '{-16'sd1, -16'sd1, 16'sd1, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b0, '0},
        // Fallback Z in use, both Z present with the primary taken, then a zero fallback Z.
        '{THR_TOP, '{16'sd100, -16'sd200, 16'h8000, 16'sd300,
          1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{THR_TOP, '{-16'sd300, 16'sd40, 16'sd50, 16'h8000,
          1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{THR_TOP, '{16'sd12, -16'sd5, 16'sd7, 16'sd0, 1'b1, 1'b1, 1'b0, 1'b1},
          1'b1, '0},
        // Shock limit: a sum equal to the threshold passes, one above fails.
        '{32'd3, '{16'sd1, 16'sd1, 16'sd1, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b0, '0},
        '{32'd3, '{16'sd1, -16'sd1, 16'sd2, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b1, '0},
        '{32'd0, '{16'sd1, 16'sd1, 16'sd1, 16'sd0, 1'b1, 1'b1, 1'b1, 1'b0},
          1'b1, '0}
    };

    // Arctangent of 2^-i, in units of 0.01 degree / 65536.
    localparam longint ATAN_STEP [29] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
        22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    atl_sample_if sample_ch ();
    atl_result_if result_ch ();

    accel_tilt_angles u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch.sink),
        .result  (result_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [31:0] shock_limit;
    tilt_t       tilt_pending [$];
    int          mismatches;
    int          cfg_errors;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_request;
    int          hold_seen;
    int          hold_left;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Integer square root, bit by bit.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC atan2(p, q) for p >= 0, in hundredths of a degree.
    function automatic longint atan2_hundredths(input longint p, input longint q);
        longint vx;
        longint vy;
        longint acc;
        longint dx;
        longint dy;
        if (q < 0)
        begin
            vx = p;
            vy = -q;
            acc = 64'sd589824000;
        end
        else
        begin
            vx = q;
            vy = p;
            acc = 0;
        end
        for (int i = 0; i < 29; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0)
            begin
                vx = vx + dx;
                vy = vy - dy;
                acc = acc + ATAN_STEP[i];
            end
            else
            begin
                vx = vx - dx;
                vy = vy + dy;
                acc = acc - ATAN_STEP[i];
            end
        end
        if (acc < 0)
            acc = 0;
        if (acc > 64'sd1179648000)
            acc = 64'sd1179648000;
        return (acc + 32768) >>> 16;
    endfunction

    // Expected tilt result of one sample set under the current threshold.
    function automatic tilt_t tilt_of(input sample_set_t s);
        tilt_t           t;
        longint          x;
        longint          y;
        longint          z;
        longint          root;
        longint          ax;
        longint          ay;
        longint          a_xoz;
        longint          a_yoz;
        longint unsigned sum;
        t = '0;
        x = s.x;
        y = s.y;
        if (s.zpp)
            z = s.zp;
        else if (s.zfp)
            z = s.zf;
        else
            return t;
        if (!s.xp || !s.yp || z <= 0 || x == 0 || y == 0)
            return t;
        sum = x * x + y * y + z * z;
        if (sum > {32'd0, shock_limit})
            return t;
        root = int_sqrt(sum << 24);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        a_xoz = atan2_hundredths(ay * root, x * z * 4096);
        a_yoz = atan2_hundredths(ax * root, y * z * 4096);
        t.ok = 1'b1;
        t.xoz = 16'((y > 0) ? 18000 + a_xoz : 18000 - a_xoz);
        t.yoz = 16'((x > 0) ? 18000 - a_yoz : 18000 + a_yoz);
        return t;
    endfunction

    // Nonzero count: full range or small magnitude, random sign.
    function automatic logic signed [15:0] rand_count(input bit full);
        logic signed [15:0] c;
        if (full)
            c = 16'($urandom);
        else
            c = 16'($urandom_range(1, 200));
        if (!full && $urandom_range(1) == 1)
            c = -c;
        if (c == 0)
            c = 16'sd1;
        return c;
    endfunction

    // Random sample set: mostly well formed, some pure noise.
    function automatic sample_set_t rand_set();
        sample_set_t s;
        bit          full;
        s = sample_set_t'({$urandom, $urandom, 4'($urandom)});
        if ($urandom_range(99) < 85)
        begin
            full = ($urandom_range(3) == 0);
            s.x = rand_count(full);
            s.y = rand_count(full);
            s.xp = 1'b1;
            s.yp = 1'b1;
            if ($urandom_range(3) == 0)
            begin
                s.zpp = 1'b0;
                s.zfp = 1'b1;
                s.zf = full ? 16'($urandom_range(1, 32767)) : 16'($urandom_range(1, 200));
            end
            else
            begin
                s.zpp = 1'b1;
                s.zp = full ? 16'($urandom_range(1, 32767)) : 16'($urandom_range(1, 200));
            end
        end
        return s;
    endfunction

    // Offer one request and hold it until the block accepts it.
    task automatic offer(input sample_set_t s);
        sample_ch.valid <= 1'b1;
        sample_ch.x_count <= s.x;
        sample_ch.y_count <= s.y;
        sample_ch.z_primary_count <= s.zp;
        sample_ch.z_fallback_count <= s.zf;
        sample_ch.x_present <= s.xp;
        sample_ch.y_present <= s.yp;
        sample_ch.z_primary_present <= s.zpp;
        sample_ch.z_fallback_present <= s.zfp;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and idle at random after an accepted request.
    task automatic maybe_idle();
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (tilt_pending.size() != 0)
            @(posedge clk);
    endtask

    // Write the shock threshold once the pipeline is empty, then read it back.
    task automatic write_threshold(input logic [31:0] v);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_SHOCK);
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shock_limit = v;
        @(posedge clk);
        if (prdata !== v)
        begin
            cfg_errors++;
            $display("threshold readback: expected %0d, got %0d", v, prdata);
        end
    endtask

    // Record the expected result of every accepted request.
    int row_now;
    bit row_typed;
    tilt_t row_tilt;
    always @(posedge clk)
    begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            if (row_typed)
                tilt_pending.push_back(row_tilt);
            else
                tilt_pending.push_back(tilt_of('{sample_ch.x_count, sample_ch.y_count,
                    sample_ch.z_primary_count, sample_ch.z_fallback_count,
                    sample_ch.x_present, sample_ch.y_present,
                    sample_ch.z_primary_present, sample_ch.z_fallback_present}));
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        tilt_t want;
        tilt_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.set_ok, result_ch.angle_xoz, result_ch.angle_yoz};
            if (tilt_pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: ok=%0d xoz=%0d yoz=%0d",
                        got.ok, got.xoz, got.yoz);
            end
            else
            begin
                want = tilt_pending.pop_front();
                if (got.ok !== want.ok || got.xoz !== want.xoz || got.yoz !== want.yoz)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: want %0d/%0d/%0d, got %0d/%0d/%0d",
                            want.ok, want.xoz, want.yoz, got.ok, got.xoz, got.yoz);
                end
            end
        end
    end

    // Result side: random stalls plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen <= hold_request;
            hold_left <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Main sequence: reset, stimulus table, then random phases.
    initial
    begin
        int pct_send [4];
        int pct_recv [4];
        logic [31:0] thr_phase [4];
        pct_send = '{0, 50, 0, 25};
        pct_recv = '{0, 0, 50, 25};
        thr_phase = '{THR_TOP, 32'd1073741824, 32'd65535,
            32'($urandom_range(100000, 32'd3221225472))};
        cfg_errors = 0;
        shock_limit = SHOCK_RESET;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        row_typed = 1'b0;
        row_tilt = '0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.x_count <= '0;
        sample_ch.y_count <= '0;
        sample_ch.z_primary_count <= '0;
        sample_ch.z_fallback_count <= '0;
        sample_ch.x_present <= 1'b0;
        sample_ch.y_present <= 1'b0;
        sample_ch.z_primary_present <= 1'b0;
        sample_ch.z_fallback_present <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stimulus table, one request at a time so typed rows line up.
        for (row_now = 0; row_now < N_ROWS; row_now++)
        begin
            if (TILT_ROWS[row_now].thr != shock_limit)
                write_threshold(TILT_ROWS[row_now].thr);
            drain();
            row_typed = TILT_ROWS[row_now].typed;
            row_tilt = TILT_ROWS[row_now].tilt;
            offer(TILT_ROWS[row_now].set);
            sample_ch.valid <= 1'b0;
            @(posedge clk);
            row_typed = 1'b0;
        end

        // Random phases with different idle patterns and thresholds.
        for (int p = 0; p < 4; p++)
        begin
            write_threshold(thr_phase[p]);
            send_idle_pct = pct_send[p];
            recv_stall_pct = pct_recv[p];
            for (int n = 0; n < 450; n++)
            begin
                if (p == 1 && n == 100)
                    hold_request++;
                if (p == 2 && n == 200)
                    drain();
                offer(rand_set());
                maybe_idle();
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && cfg_errors == 0 && tilt_pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
